// ----- sv/crs_pkg.sv -----
`default_nettype none

package crs_pkg;

    // Field widths
    localparam int OP_W      = 4;
    localparam int LEN_W     = 28;
    localparam int START_W   = 31;
    localparam int OFFSET_W  = 42;
    localparam int ACC_W     = 32;
    localparam int POS_W     = 43;
    localparam int TOTAL_W   = ACC_W + 2;
    localparam int MAXLEN_W  = 24;
    localparam int BINNUM_W  = 16;
    localparam int BINPOS_W  = 27;

    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 24'd10000;

    // CIGAR operation codes
    localparam logic [OP_W-1:0] OP_M  = 4'd0;
    localparam logic [OP_W-1:0] OP_I  = 4'd1;
    localparam logic [OP_W-1:0] OP_D  = 4'd2;
    localparam logic [OP_W-1:0] OP_N  = 4'd3;
    localparam logic [OP_W-1:0] OP_S  = 4'd4;
    localparam logic [OP_W-1:0] OP_H  = 4'd5;
    localparam logic [OP_W-1:0] OP_EQ = 4'd7;
    localparam logic [OP_W-1:0] OP_X  = 4'd8;

    typedef logic [ACC_W-1:0] acc_t;
    typedef logic [POS_W-1:0] pos_t;

endpackage

`default_nettype wire

// ----- sv/cigar_read_signature.sv -----
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+---------------------------------------------
// s_       | in        | s_valid / s_ready  | op_code, op_length, last_op, read_start,
//          |           |                    | contig_offset, reverse_strand
// m_       | out       | m_valid / m_ready  | bin_number, bin_position, reference_length,
//          |           |                    | read_too_long, bad_operation
// cfg_     | in        | cfg_wr_en          | cfg_wr_data (max_read_length)
//
// One CIGAR operation is taken per cycle while s_ready is high; accumulators update
// at the input transfer. A last operation passes the snapshot register, then the result
// register: base position add before the snapshot, position/length check after it.
// Synchronous active-low reset clears accumulators and stage valids, limit back to 10000.
// s_ready drops only while both the snapshot stage and the result register are full
// and m_ready is low; non-final operations never produce a result.
module cigar_read_signature #(
    parameter int BIN_BITS = 27
) (
    input  wire                                aclk,
    input  wire                                aresetn,

    input  wire                                cfg_wr_en,
    input  wire  [crs_pkg::MAXLEN_W-1:0]       cfg_wr_data,

    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  [crs_pkg::OP_W-1:0]           s_op_code,
    input  wire  [crs_pkg::LEN_W-1:0]          s_op_length,
    input  wire                                s_last_op,
    input  wire  [crs_pkg::START_W-1:0]        s_read_start,
    input  wire  [crs_pkg::OFFSET_W-1:0]       s_contig_offset,
    input  wire                                s_reverse_strand,

    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [crs_pkg::BINNUM_W-1:0]       m_bin_number,
    output logic [crs_pkg::BINPOS_W-1:0]       m_bin_position,
    output logic [crs_pkg::ACC_W-1:0]          m_reference_length,
    output logic                               m_read_too_long,
    output logic                               m_bad_operation
);
    import crs_pkg::*;

    // Configuration
    logic [MAXLEN_W-1:0] max_len_reg;

    // Running per-read state
    acc_t ref_acc_reg,   ref_acc_next;
    acc_t query_acc_reg, query_acc_next;
    acc_t lead_acc_reg,  lead_acc_next;
    acc_t trail_acc_reg, trail_acc_next;
    logic before_first_reg, before_first_next;
    logic saw_bad_reg,      saw_bad_next;

    // Updated values for the operation in transfer
    acc_t ref_upd, query_upd, lead_upd, trail_upd;
    logic before_first_upd, saw_bad_upd, op_bad;
    acc_t len_ext;

    // Snapshot stage
    logic s1_valid_reg, s1_valid_next;
    acc_t snap_ref_reg, snap_query_reg, snap_lead_reg, snap_trail_reg;
    logic snap_bad_reg, snap_rev_reg;
    pos_t snap_base_reg;

    // Result stage
    logic                m_valid_reg, m_valid_next;
    logic [BINNUM_W-1:0] out_bin_num_reg;
    logic [BINPOS_W-1:0] out_bin_pos_reg;
    acc_t                out_ref_reg;
    logic                out_too_long_reg, out_bad_reg;

    logic in_xfer, s1_load, s1_move;
    pos_t base_pos, pos_fwd, pos_rev, pos_sel, pos_hi, pos_lo;
    logic [TOTAL_W-1:0] total_len;
    logic               too_long;

    // Handshake
    assign s1_move = s1_valid_reg & (~m_valid_reg | m_ready);
    assign s_ready = ~s1_valid_reg | ~m_valid_reg | m_ready;
    assign in_xfer = s_valid & s_ready;
    assign s1_load = in_xfer & s_last_op;

    // Accumulate the operation in transfer
    assign len_ext = {{(ACC_W-LEN_W){1'b0}}, s_op_length};

    always_comb begin
        ref_upd          = ref_acc_reg;
        query_upd        = query_acc_reg;
        lead_upd         = lead_acc_reg;
        trail_upd        = trail_acc_reg;
        before_first_upd = before_first_reg;
        saw_bad_upd      = saw_bad_reg;
        op_bad           = 1'b0;
        case (s_op_code)
            OP_M, OP_EQ, OP_X: begin
                ref_upd          = ref_acc_reg + len_ext;
                query_upd        = query_acc_reg + len_ext;
                before_first_upd = 1'b0;
            end
            OP_I: begin
                query_upd        = query_acc_reg + len_ext;
                before_first_upd = 1'b0;
            end
            OP_D, OP_N: begin
                ref_upd          = ref_acc_reg + len_ext;
                before_first_upd = 1'b0;
            end
            OP_S, OP_H: begin
                if (before_first_reg) begin
                    lead_upd = lead_acc_reg + len_ext;
                end else begin
                    trail_upd = trail_acc_reg + len_ext;
                end
            end
            default: begin
                op_bad      = 1'b1;
                saw_bad_upd = 1'b1;
            end
        endcase
    end

    // Clear the running state after a last operation, otherwise hold or advance
    always_comb begin
        ref_acc_next      = ref_acc_reg;
        query_acc_next    = query_acc_reg;
        lead_acc_next     = lead_acc_reg;
        trail_acc_next    = trail_acc_reg;
        before_first_next = before_first_reg;
        saw_bad_next      = saw_bad_reg;
        if (in_xfer) begin
            if (s_last_op) begin
                ref_acc_next      = '0;
                query_acc_next    = '0;
                lead_acc_next     = '0;
                trail_acc_next    = '0;
                before_first_next = 1'b1;
                saw_bad_next      = 1'b0;
            end else begin
                ref_acc_next      = ref_upd;
                query_acc_next    = query_upd;
                lead_acc_next     = lead_upd;
                trail_acc_next    = trail_upd;
                before_first_next = before_first_upd;
                saw_bad_next      = saw_bad_upd;
            end
        end
    end

    assign base_pos = {1'b0, s_contig_offset} + {{(POS_W-START_W){1'b0}}, s_read_start};

    // Signature position and length check from the snapshot
    assign pos_fwd   = snap_base_reg - {{(POS_W-ACC_W){1'b0}}, snap_lead_reg};
    assign pos_rev   = snap_base_reg + {{(POS_W-ACC_W){1'b0}}, snap_ref_reg}
                     + {{(POS_W-ACC_W){1'b0}}, snap_trail_reg};
    assign pos_sel   = snap_rev_reg ? pos_rev : pos_fwd;
    assign pos_hi    = pos_sel >> BIN_BITS;
    assign pos_lo    = pos_sel & ((POS_W'(1) << BIN_BITS) - POS_W'(1));
    assign total_len = {2'b00, snap_lead_reg} + {2'b00, snap_query_reg}
                     + {2'b00, snap_trail_reg};
    assign too_long  = total_len > {{(TOTAL_W-MAXLEN_W){1'b0}}, max_len_reg};

    assign s1_valid_next = s1_load | (s1_valid_reg & ~s1_move);
    assign m_valid_next  = s1_valid_reg | (m_valid_reg & ~m_ready);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg      <= MAXLEN_RESET;
            ref_acc_reg      <= '0;
            query_acc_reg    <= '0;
            lead_acc_reg     <= '0;
            trail_acc_reg    <= '0;
            before_first_reg <= 1'b1;
            saw_bad_reg      <= 1'b0;
            s1_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
            ref_acc_reg      <= ref_acc_next;
            query_acc_reg    <= query_acc_next;
            lead_acc_reg     <= lead_acc_next;
            trail_acc_reg    <= trail_acc_next;
            before_first_reg <= before_first_next;
            saw_bad_reg      <= saw_bad_next;
            s1_valid_reg     <= s1_valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Capture the finished read
    always_ff @(posedge aclk) begin
        if (s1_load) begin
            snap_ref_reg   <= ref_upd;
            snap_query_reg <= query_upd;
            snap_lead_reg  <= lead_upd;
            snap_trail_reg <= trail_upd;
            snap_bad_reg   <= saw_bad_upd;
            snap_rev_reg   <= s_reverse_strand;
            snap_base_reg  <= base_pos;
        end
    end

    // Load the result register
    always_ff @(posedge aclk) begin
        if (s1_move) begin
            out_bin_num_reg  <= pos_hi[BINNUM_W-1:0];
            out_bin_pos_reg  <= pos_lo[BINPOS_W-1:0];
            out_ref_reg      <= snap_ref_reg;
            out_too_long_reg <= too_long;
            out_bad_reg      <= snap_bad_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_bin_number       = out_bin_num_reg;
    assign m_bin_position     = out_bin_pos_reg;
    assign m_reference_length = out_ref_reg;
    assign m_read_too_long    = out_too_long_reg;
    assign m_bad_operation    = out_bad_reg;

    // A last operation restarts the per-read state
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_load |=> (ref_acc_reg == '0) && (lead_acc_reg == '0) && before_first_reg
                    && !saw_bad_reg)
        else $error("per-read state not cleared after last operation");

    // A result only appears after the snapshot stage held a read
    a_result_from_snapshot: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_valid_reg))
        else $error("result raised without a snapshot");

    // A stalled snapshot is kept
    a_snapshot_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_ready) |=> s1_valid_reg && $stable(snap_base_reg))
        else $error("snapshot dropped during stall");

    // An invalid code inside a read is remembered
    a_bad_op_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && !s_last_op && op_bad) |=> saw_bad_reg)
        else $error("invalid operation not recorded");

endmodule

`default_nettype wire

// ----- tb/sv/sig_check_pkg.sv -----
`default_nettype none

package sig_check_pkg;

    import crs_pkg::*;

    localparam int SIG_BIN_BITS = 27;

    // Codes the block does not recognize
    localparam logic [OP_W-1:0] OP_UNUSED   = 4'd6;
    localparam logic [OP_W-1:0] OP_CODE_MAX = 4'd15;

    typedef struct packed {
        logic [BINNUM_W-1:0] bin_number;
        logic [BINPOS_W-1:0] bin_position;
        acc_t                reference_length;
        logic                read_too_long;
        logic                bad_operation;
    } sig_entry_t;

    class signature_scoreboard;
        sig_entry_t          expected_sigs[$];
        acc_t                ref_span;
        acc_t                query_span;
        acc_t                head_clip;
        acc_t                tail_clip;
        logic                in_head;
        logic                bad_seen;
        logic [MAXLEN_W-1:0] max_len;
        int                  fails;
        int                  ops_noted;
        int                  reads_done;
        int                  bad_reads;
        int                  long_reads;

        function new();
            max_len    = MAXLEN_RESET;
            fails      = 0;
            ops_noted  = 0;
            reads_done = 0;
            bad_reads  = 0;
            long_reads = 0;
            clear_read();
        endfunction

        function void clear_read();
            ref_span   = '0;
            query_span = '0;
            head_clip  = '0;
            tail_clip  = '0;
            in_head    = 1'b1;
            bad_seen   = 1'b0;
        endfunction

        function void set_max_len(logic [MAXLEN_W-1:0] value);
            max_len = value;
        endfunction

        function int pending();
            return expected_sigs.size();
        endfunction

        // Accumulate one accepted CIGAR operation; a last one yields a signature
        function void note_op(logic [OP_W-1:0] code, logic [LEN_W-1:0] len, logic last,
                              logic [START_W-1:0] start, logic [OFFSET_W-1:0] offset,
                              logic rev);
            logic [63:0]        pos;
            logic [TOTAL_W-1:0] total;
            sig_entry_t         sig;
            ops_noted++;
            case (code)
                OP_M, OP_EQ, OP_X: begin
                    ref_span   += ACC_W'(len);
                    query_span += ACC_W'(len);
                    in_head     = 1'b0;
                end
                OP_I: begin
                    query_span += ACC_W'(len);
                    in_head     = 1'b0;
                end
                OP_D, OP_N: begin
                    ref_span += ACC_W'(len);
                    in_head   = 1'b0;
                end
                OP_S, OP_H: begin
                    if (in_head) begin
                        head_clip += ACC_W'(len);
                    end else begin
                        tail_clip += ACC_W'(len);
                    end
                end
                default: begin
                    bad_seen = 1'b1;
                end
            endcase
            if (!last) return;

            // Reverse reads point past the aligned span, forward reads before the clips
            if (rev) begin
                pos = 64'(offset) + 64'(start) + 64'(ref_span) + 64'(tail_clip);
            end else begin
                pos = 64'(offset) + 64'(start) - 64'(head_clip);
            end
            total = TOTAL_W'(head_clip) + TOTAL_W'(query_span) + TOTAL_W'(tail_clip);

            sig.bin_number       = pos[POS_W-1:SIG_BIN_BITS];
            sig.bin_position     = pos[SIG_BIN_BITS-1:0];
            sig.reference_length = ref_span;
            sig.read_too_long    = (total > TOTAL_W'(max_len));
            sig.bad_operation    = bad_seen;
            expected_sigs.push_back(sig);

            reads_done++;
            if (sig.bad_operation) bad_reads++;
            if (sig.read_too_long) long_reads++;
            clear_read();
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
                fails++;
            end
        endfunction

        // Match one result transfer against the oldest pending signature
        function void check_result(logic [BINNUM_W-1:0] bin_number,
                                   logic [BINPOS_W-1:0] bin_position, acc_t reference_length,
                                   logic read_too_long, logic bad_operation);
            sig_entry_t want;
            if (expected_sigs.size() == 0) begin
                $display("%0t: result with none pending, expected nothing actual bin %0h pos %0h",
                         $time, bin_number, bin_position);
                fails++;
                return;
            end
            want = expected_sigs.pop_front();
            compare_field("bin_number", 64'(want.bin_number), 64'(bin_number));
            compare_field("bin_position", 64'(want.bin_position), 64'(bin_position));
            compare_field("reference_length", 64'(want.reference_length),
                          64'(reference_length));
            compare_field("read_too_long", 64'(want.read_too_long), 64'(read_too_long));
            compare_field("bad_operation", 64'(want.bad_operation), 64'(bad_operation));
        endfunction
    endclass

endpackage

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none

module tb_top;

    import crs_pkg::*;
    import sig_check_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 6;
    localparam int OVERFLOW_OPS  = 30;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [MAXLEN_W-1:0]  cfg_wr_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [OP_W-1:0]      s_op_code = '0;
    logic [LEN_W-1:0]     s_op_length = '0;
    logic                 s_last_op = 1'b0;
    logic [START_W-1:0]   s_read_start = '0;
    logic [OFFSET_W-1:0]  s_contig_offset = '0;
    logic                 s_reverse_strand = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [BINNUM_W-1:0]  m_bin_number;
    logic [BINPOS_W-1:0]  m_bin_position;
    logic [ACC_W-1:0]     m_reference_length;
    logic                 m_read_too_long;
    logic                 m_bad_operation;

    signature_scoreboard  sb;
    int unsigned          cycle_count = 0;
    int                   ops_sent = 0;
    int                   limit_settings = 0;
    int                   send_gap_max = 0;
    int                   recv_gap_max = 0;
    bit                   hold_output = 1'b0;

    cigar_read_signature #(
        .BIN_BITS(SIG_BIN_BITS)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op_code          (s_op_code),
        .s_op_length        (s_op_length),
        .s_last_op          (s_last_op),
        .s_read_start       (s_read_start),
        .s_contig_offset    (s_contig_offset),
        .s_reverse_strand   (s_reverse_strand),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_bin_number       (m_bin_number),
        .m_bin_position     (m_bin_position),
        .m_reference_length (m_reference_length),
        .m_read_too_long    (m_read_too_long),
        .m_bad_operation    (m_bad_operation)
    );

    always #5 aclk = ~aclk;

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Feed every transfer on either channel to the scoreboard
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_op(s_op_code, s_op_length, s_last_op, s_read_start, s_contig_offset,
                       s_reverse_strand);
        end
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_bin_number, m_bin_position, m_reference_length,
                            m_read_too_long, m_bad_operation);
        end
    end

    // Result side: random stalls per transfer, one long hold on request
    initial begin
        int gap;
        forever begin
            if (hold_output) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_output = 1'b0;
            end else begin
                gap = $urandom_range(0, recv_gap_max);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    function automatic logic [LEN_W-1:0] rand_len();
        int unsigned pick;
        logic [31:0] r;
        pick = $urandom_range(0, 99);
        r = $urandom;
        if (pick < 4) return '0;
        else if (pick < 8) return '1;
        else if (pick < 20) return r[LEN_W-1:0];
        else return LEN_W'($urandom_range(1, 400));
    endfunction

    function automatic logic [START_W-1:0] rand_start();
        int unsigned pick;
        logic [31:0] r;
        pick = $urandom_range(0, 99);
        r = $urandom;
        if (pick < 5) return '0;
        else if (pick < 10) return '1;
        else return r[START_W-1:0];
    endfunction

    function automatic logic [OFFSET_W-1:0] rand_offset();
        int unsigned pick;
        logic [63:0] r;
        pick = $urandom_range(0, 99);
        r = {$urandom, $urandom};
        if (pick < 5) return '0;
        else if (pick < 10) return '1;
        else if (pick < 40) return OFFSET_W'(r[19:0]);
        else return r[OFFSET_W-1:0];
    endfunction

    function automatic logic [OP_W-1:0] pick_clip();
        return ($urandom_range(0, 1) == 0) ? OP_S : OP_H;
    endfunction

    function automatic logic [OP_W-1:0] pick_aligned();
        case ($urandom_range(0, 5))
            0: return OP_M;
            1: return OP_I;
            2: return OP_D;
            3: return OP_N;
            4: return OP_EQ;
            default: return OP_X;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_bad();
        if ($urandom_range(0, 3) == 0) return OP_UNUSED;
        return OP_W'($urandom_range(32'(OP_X) + 1, 32'(OP_CODE_MAX)));
    endfunction

    // Offer one operation after a random gap and hold it until the transfer
    task automatic send_op(input logic [OP_W-1:0] code, input logic [LEN_W-1:0] len,
                           input logic last, input logic [START_W-1:0] start,
                           input logic [OFFSET_W-1:0] offset, input logic rev);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_op_code        <= code;
        s_op_length      <= len;
        s_last_op        <= last;
        s_read_start     <= start;
        s_contig_offset  <= offset;
        s_reverse_strand <= rev;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ops_sent++;
    endtask

    // Hold the input off until every pending signature has been checked
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_len(input logic [MAXLEN_W-1:0] value);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        sb.set_max_len(value);
        cfg_wr_en <= 1'b0;
        limit_settings++;
    endtask

    // Well-formed read: leading clips, aligned ops, trailing clips, maybe a bad code
    task automatic send_read(input bit with_bad);
        logic [OP_W-1:0]     codes[$];
        logic [START_W-1:0]  start;
        logic [OFFSET_W-1:0] offset;
        logic [63:0]         r;
        logic                rev;
        int                  n_lead;
        int                  n_aligned;
        int                  n_trail;
        int                  k;
        n_lead    = $urandom_range(0, 2);
        n_aligned = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
        n_trail   = $urandom_range(0, 2);
        for (k = 0; k < n_lead; k++) codes.push_back(pick_clip());
        for (k = 0; k < n_aligned; k++) codes.push_back(pick_aligned());
        for (k = 0; k < n_trail; k++) codes.push_back(pick_clip());
        if (with_bad || codes.size() == 0) begin
            codes.insert($urandom_range(0, codes.size()), pick_bad());
        end
        start  = rand_start();
        offset = rand_offset();
        r      = {$urandom, $urandom};
        rev    = r[0];
        for (k = 0; k < codes.size(); k++) begin
            if (k == codes.size() - 1) begin
                send_op(codes[k], rand_len(), 1'b1, start, offset, rev);
            end else begin
                r = {$urandom, $urandom};
                send_op(codes[k], rand_len(), 1'b0, r[62:32], r[OFFSET_W-1:0], r[63]);
            end
        end
    endtask

    // Near-maximum lengths so the counters wrap and the total exceeds 32 bits
    task automatic send_overflow_read();
        logic [OP_W-1:0] code;
        logic [63:0]     r;
        int              k;
        for (k = 0; k < OVERFLOW_OPS; k++) begin
            r = {$urandom, $urandom};
            case (k % 3)
                0: code = pick_clip();
                1: code = OP_M;
                default: code = r[8] ? OP_D : OP_EQ;
            endcase
            send_op(code, LEN_W'(28'hFFFFFFF - 28'(r[7:0])), k == OVERFLOW_OPS - 1,
                    r[62:32], r[OFFSET_W-1:0], r[63]);
        end
    endtask

    task automatic run_phase(input int op_budget);
        logic [63:0] r;
        logic [63:0] q;
        int          stop_at;
        int          sel;
        stop_at = ops_sent + op_budget;
        while (ops_sent < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
                send_read($urandom_range(0, 9) == 0);
            end else if (sel < 95) begin
                // Loose operation with any code, sometimes ending a read
                r = {$urandom, $urandom};
                q = {$urandom, $urandom};
                send_op(r[3:0], rand_len(), r[5:4] == 2'd0, q[62:32], q[OFFSET_W-1:0],
                        q[63]);
            end else if (sel < 97) begin
                send_overflow_read();
            end else begin
                wait_for_results();
            end
        end
        // Close any open read before the phase ends
        send_read(1'b0);
    endtask

    task automatic run_directed();
        // All-zero single-op read
        send_op(OP_M, '0, 1'b1, '0, '0, 1'b0);
        // Every valid code, leading and trailing clips, reverse strand
        send_op(OP_S, 28'd5, 1'b0, '0, '0, 1'b0);
        send_op(OP_H, 28'd3, 1'b0, '0, '0, 1'b0);
        send_op(OP_M, 28'd100, 1'b0, '0, '0, 1'b0);
        send_op(OP_I, 28'd3, 1'b0, '0, '0, 1'b0);
        send_op(OP_D, 28'd4, 1'b0, '0, '0, 1'b0);
        send_op(OP_N, 28'd7, 1'b0, '0, '0, 1'b0);
        send_op(OP_EQ, 28'd2, 1'b0, '0, '0, 1'b0);
        send_op(OP_X, 28'd1, 1'b0, '0, '0, 1'b0);
        send_op(OP_S, 28'd9, 1'b1, 31'd1000, 42'd5000, 1'b1);
        // Forward position below zero wraps
        send_op(OP_H, 28'd1000, 1'b0, '0, '0, 1'b0);
        send_op(OP_M, 28'd10, 1'b1, '0, '0, 1'b0);
        // Reverse position at the top of the range: all-ones start, offset and length
        send_op(OP_M, '1, 1'b1, '1, '1, 1'b1);
        // Invalid codes: length ignored, clip phase untouched
        send_op(OP_UNUSED, 28'd50, 1'b0, '0, '0, 1'b0);
        send_op(OP_M, 28'd20, 1'b1, 31'd77, 42'd300, 1'b0);
        send_op(OP_CODE_MAX, 28'd7, 1'b1, 31'd5, 42'd9, 1'b0);
        send_op(OP_S, 28'd5, 1'b0, '0, '0, 1'b0);
        send_op(OP_UNUSED, 28'd11, 1'b0, '0, '0, 1'b0);
        send_op(OP_S, 28'd6, 1'b1, 31'd100, 42'd100, 1'b0);
        // Length limit: exactly at it, one over, over through clips and an insertion
        send_op(OP_M, 28'd10000, 1'b1, 31'd1, 42'd1, 1'b0);
        send_op(OP_M, 28'd10001, 1'b1, 31'd1, 42'd1, 1'b1);
        send_op(OP_S, 28'd4000, 1'b0, '0, '0, 1'b0);
        send_op(OP_I, 28'd3000, 1'b0, '0, '0, 1'b0);
        send_op(OP_H, 28'd3001, 1'b1, 31'd50, 42'd60, 1'b1);
    endtask

    initial begin
        int k;
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_gap_max = 3;
        recv_gap_max = 3;
        run_directed();

        // Tightest limit, full idling on both sides
        write_max_len('0);
        send_gap_max = 6;
        recv_gap_max = 6;
        run_phase(120);

        // Widest limit; hold the output long while back-to-back reads pile up
        write_max_len('1);
        send_gap_max = 0;
        recv_gap_max = 0;
        hold_output  = 1'b1;
        for (k = 0; k < 16; k++) begin
            send_op(OP_M, rand_len(), 1'b1, rand_start(), rand_offset(), k[0]);
        end
        run_phase(130);

        write_max_len(MAXLEN_W'($urandom));
        send_gap_max = 6;
        recv_gap_max = 6;
        run_phase(150);

        write_max_len(MAXLEN_W'($urandom_range(0, 2000)));
        send_gap_max = 0;
        recv_gap_max = 6;
        run_phase(150);

        write_max_len(MAXLEN_W'($urandom));
        send_gap_max = 6;
        recv_gap_max = 0;
        run_phase(150);

        wait_for_results();
        $display("covered %0d operations in %0d reads under %0d length limits",
                 sb.ops_noted, sb.reads_done, limit_settings + 1);
        $display("%0d reads carried an invalid code, %0d exceeded their limit",
                 sb.bad_reads, sb.long_reads);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
sv/crs_pkg.sv
sv/cigar_read_signature.sv
tb/sv/sig_check_pkg.sv
tb/sv/tb_top.sv
